// ===== rtl/wecc_pkg.sv =====
// Package for the window endpoint / corner classifier.
// Holds field widths, register indexes, frame limits and result kinds.
// No dependencies; the interfaces and the top level import it.
package wecc_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_DIM    = 3;

  localparam int PIXEL_W = 32;
  localparam int CFG_W   = 11;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int COORD_W = 10;
  localparam int COUNT_W = 3;
  localparam int IDX_W   = 2;

  localparam logic [PIXEL_W-1:0] BACKGROUND = 32'hFFFF_FFFF;

  localparam logic [IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam logic KIND_ENDPOINT = 1'b0;
  localparam logic KIND_CORNER   = 1'b1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

  // Each line store entry packs the upper row bit (1) and middle row bit (0).
  localparam int STORE_W = 2;

endpackage

// ===== rtl/wecc_if.sv =====
// Valid/ready stream interfaces for the classifier's pixel and result channels.
// Depends on wecc_pkg for payload widths.
interface wecc_in_if import wecc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface wecc_out_if import wecc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] center_x;
  logic [COORD_W-1:0] center_y;
  logic               kind;
  logic [COUNT_W-1:0] ones_count;

  modport source (output valid, output center_x, output center_y, output kind,
                  output ones_count, input ready);
  modport sink   (input valid, input center_x, input center_y, input kind,
                  input ones_count, output ready);
endinterface

// ===== rtl/wecc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing; used for the classifier's line stores.
module wecc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/window_endpoint_corner_classifier.sv =====
// Top level of the 3x3 window endpoint / corner classifier.
// Depends on wecc_pkg, wecc_if (stream interfaces) and wecc_ram (line stores).
//
//   channel  | dir | transfer when        | payload
//   ---------+-----+----------------------+----------------------------------------
//   in_chan  | in  | valid && ready       | pixel[31:0]
//   out_chan | out | valid && ready       | center_x, center_y, kind, ones_count
//   cfg_*    | in  | cfg_wr_en            | cfg_index, cfg_wdata[10:0]
//
// One pixel per cycle sustained while out_chan is not stalled; a transferred pixel
// loads the read stage (line store read), then its window count loads the output
// register, from which the result transfers.
// After reset a clearing pass zeroes all 1024 line store entries, one entry per
// cycle; in_chan.ready stays low meanwhile, configuration writes still land.
// A stalled result holds the window stage; one pixel may still enter behind it.
module window_endpoint_corner_classifier import wecc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  wecc_in_if.sink          in_chan,
  wecc_out_if.source       out_chan,
  input  logic             cfg_wr_en,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  // configuration
  logic [CFG_W-1:0] width_r, height_r;
  logic [CFG_W-1:0] width_eff, height_eff;

  // clearing pass
  logic             clr_busy_r;
  logic [COL_W-1:0] clr_addr_r;

  // position counters
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  // read stage
  logic             s1_valid_r;
  logic [COL_W-1:0] s1_col_r;
  logic [ROW_W-1:0] s1_row_r;
  logic             s1_bit_r;
  logic             s1_adv;

  // window and result
  logic [8:0]         window_r, window_nxt;
  logic [3:0]         cnt;
  logic               produce;
  logic               out_valid_r;
  logic [COORD_W-1:0] cx_r, cy_r;
  logic               kind_r;
  logic [COUNT_W-1:0] ones_r;

  // line store
  logic [STORE_W-1:0] rd_data, wr_data;
  logic [COL_W-1:0]   wr_addr;
  logic               wr_en;
  logic               accept;

  always_comb begin
    if (width_r < CFG_W'(MIN_DIM))         width_eff = CFG_W'(MIN_DIM);
    else if (width_r > CFG_W'(MAX_WIDTH))  width_eff = CFG_W'(MAX_WIDTH);
    else                                   width_eff = width_r;
    if (height_r < CFG_W'(MIN_DIM))        height_eff = CFG_W'(MIN_DIM);
    else if (height_r > CFG_W'(MAX_HEIGHT)) height_eff = CFG_W'(MAX_HEIGHT);
    else                                   height_eff = height_r;
  end

  assign s1_adv         = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready  = !clr_busy_r && (!s1_valid_r || s1_adv);
  assign accept         = in_chan.valid && in_chan.ready;

  // advance raster position, wrap at row and frame end
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if ({1'b0, col_r} + 1'b1 >= width_eff) begin
      col_nxt = '0;
      if ({1'b0, row_r} + 1'b1 >= height_eff) row_nxt = '0;
      else                                     row_nxt = row_r + 1'b1;
    end else begin
      col_nxt = col_r + 1'b1;
    end
  end

  // shift in the new column: bit 0 top row, bit 1 middle, bit 2 bottom
  always_comb begin
    window_nxt = {window_r[5:0], s1_bit_r, rd_data[0], rd_data[1]};
    cnt = '0;
    for (int i = 0; i < 9; i++) begin
      cnt = cnt + {3'b000, window_nxt[i]};
    end
    produce = (s1_col_r >= COL_W'(2)) && (s1_row_r >= ROW_W'(2)) &&
              (cnt == 4'd1 || cnt == 4'd3 || cnt == 4'd5);
  end

  // clearing pass writes zeros; otherwise middle row moves up, new pixel becomes the middle row
  always_comb begin
    if (clr_busy_r) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = '0;
    end else begin
      wr_en   = s1_adv;
      wr_addr = s1_col_r;
      wr_data = {rd_data[0], s1_bit_r};
    end
  end

  wecc_ram #(
    .WIDTH (STORE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (accept),
    .raddr (col_r),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= WIDTH_RESET;
      height_r    <= HEIGHT_RESET;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      col_r       <= '0;
      row_r       <= '0;
      s1_valid_r  <= 1'b0;
      window_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en && cfg_index == CFG_FRAME_WIDTH)  width_r  <= cfg_wdata;
      if (cfg_wr_en && cfg_index == CFG_FRAME_HEIGHT) height_r <= cfg_wdata;

      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == COL_W'(MAX_WIDTH - 1)) clr_busy_r <= 1'b0;
      end

      if (accept) begin
        col_r      <= col_nxt;
        row_r      <= row_nxt;
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_adv) window_r <= window_nxt;

      if (s1_adv && produce)   out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_r <= col_r;
      s1_row_r <= row_r;
      s1_bit_r <= (in_chan.pixel != BACKGROUND);
    end
    if (s1_adv && produce) begin
      cx_r   <= COORD_W'(s1_col_r - 1'b1);
      cy_r   <= COORD_W'(s1_row_r - 1'b1);
      kind_r <= (cnt == 4'd1) ? KIND_ENDPOINT : KIND_CORNER;
      ones_r <= cnt[COUNT_W-1:0];
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.center_x   = cx_r;
  assign out_chan.center_y   = cy_r;
  assign out_chan.kind       = kind_r;
  assign out_chan.ones_count = ones_r;

endmodule
